// ===== rtl/core/dtfe_pkg.sv =====
// Package for the date and time field editor.
// Holds event codes, field limits and the event and result transaction types.
// No dependencies.
package dtfe_pkg;

	// event codes
	localparam logic [2:0] MODE_UP    = 3'd0;
	localparam logic [2:0] MODE_DOWN  = 3'd1;
	localparam logic [2:0] MODE_OK    = 3'd2;
	localparam logic [2:0] MODE_BACK  = 3'd3;
	localparam logic [2:0] MODE_START = 3'd4;

	// cursor positions
	localparam logic [2:0] FIELD_DATE    = 3'd0;
	localparam logic [2:0] FIELD_MONTH   = 3'd1;
	localparam logic [2:0] FIELD_YEAR    = 3'd2;
	localparam logic [2:0] FIELD_HOURS   = 3'd3;
	localparam logic [2:0] FIELD_MINUTES = 3'd4;
	localparam logic [2:0] FIELD_END     = 3'd5;

	// wrap limits of each field
	localparam logic [6:0] DATE_MIN    = 7'd1;
	localparam logic [6:0] DATE_MAX    = 7'd31;
	localparam logic [6:0] MONTH_MIN   = 7'd1;
	localparam logic [6:0] MONTH_MAX   = 7'd12;
	localparam logic [6:0] YEAR_MIN    = 7'd0;
	localparam logic [6:0] YEAR_MAX    = 7'd99;
	localparam logic [6:0] HOURS_MIN   = 7'd0;
	localparam logic [6:0] HOURS_MAX   = 7'd23;
	localparam logic [6:0] MINUTES_MIN = 7'd0;
	localparam logic [6:0] MINUTES_MAX = 7'd59;

	typedef struct packed {
		logic [2:0] mode;
		logic [4:0] load_date;
		logic [3:0] load_month;
		logic [6:0] load_year;
		logic [4:0] load_hours;
		logic [5:0] load_minutes;
	} event_t;

	typedef struct packed {
		logic [4:0] cur_date;
		logic [3:0] cur_month;
		logic [6:0] cur_year;
		logic [4:0] cur_hours;
		logic [5:0] cur_minutes;
		logic [2:0] field_index;
		logic       write_clock;
		logic       finished;
	} result_t;

endpackage

// ===== rtl/core/datetime_field_editor_unit.sv =====
// Date and time field editor, top level.
// Depends on dtfe_pkg for event codes, field limits and transaction types.

// Each button event transaction is turned into one result transaction: the
// session state and the result register update together at the edge that
// accepts the event, so a new event is taken every cycle while event_stall is
// low; result_valid rises in the cycle after acceptance. The event side
// stalls only while a result is held and the result side stalls. Out-of-range
// loads stay as loaded; up/down wraps them, but down above max decrements.
module datetime_field_editor_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              event_valid,
	output logic              event_stall,
	input  dtfe_pkg::event_t  event_data,
	output logic              result_valid,
	input  logic              result_stall,
	output dtfe_pkg::result_t result_data
);
	import dtfe_pkg::*;

	// session state
	logic       open_q;
	logic [2:0] cursor_q;
	logic [4:0] day_q;
	logic [3:0] month_q;
	logic [6:0] year_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;

	logic       open_n;
	logic [2:0] cursor_n;
	logic [4:0] day_n;
	logic [3:0] month_n;
	logic [6:0] year_n;
	logic [4:0] hour_n;
	logic [5:0] minute_n;
	logic       write_n;
	logic       fin_n;
	logic       adj_up;
	logic       accept;

	// wrap one field up or down between its limits
	function automatic logic [6:0] step_field(input logic [6:0] v, input logic [6:0] lo,
			input logic [6:0] hi, input logic up);
		if (up) begin
			return (v < hi) ? v + 7'd1 : lo;
		end else begin
			return (v > lo) ? v - 7'd1 : hi;
		end
	endfunction

	// handshake: the event side waits only on a held, stalled result
	assign event_stall = result_valid && result_stall;
	assign accept      = event_valid && !event_stall;
	assign adj_up      = (event_data.mode == MODE_UP);

	// next state and result for the incoming event
	always_comb begin
		open_n   = open_q;
		cursor_n = cursor_q;
		day_n    = day_q;
		month_n  = month_q;
		year_n   = year_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		write_n  = 1'b0;
		fin_n    = 1'b0;
		if (event_data.mode == MODE_START) begin
			day_n    = event_data.load_date;
			month_n  = event_data.load_month;
			year_n   = event_data.load_year;
			hour_n   = event_data.load_hours;
			minute_n = event_data.load_minutes;
			cursor_n = FIELD_DATE;
			open_n   = 1'b1;
		end else if (open_q) begin
			unique case (event_data.mode)
				MODE_UP, MODE_DOWN: begin
					unique case (cursor_q)
						FIELD_DATE: begin
							day_n = 5'(step_field({2'b00, day_q}, DATE_MIN, DATE_MAX, adj_up));
						end
						FIELD_MONTH: begin
							month_n = 4'(step_field({3'b000, month_q}, MONTH_MIN, MONTH_MAX,
								adj_up));
						end
						FIELD_YEAR: begin
							year_n = step_field(year_q, YEAR_MIN, YEAR_MAX, adj_up);
						end
						FIELD_HOURS: begin
							hour_n = 5'(step_field({2'b00, hour_q}, HOURS_MIN, HOURS_MAX,
								adj_up));
						end
						FIELD_MINUTES: begin
							minute_n = 6'(step_field({1'b0, minute_q}, MINUTES_MIN,
								MINUTES_MAX, adj_up));
						end
						default: begin
						end
					endcase
				end
				MODE_OK: begin
					write_n = 1'b1;
					if (cursor_q >= FIELD_MINUTES) begin
						cursor_n = FIELD_END;
						open_n   = 1'b0;
						fin_n    = 1'b1;
					end else begin
						cursor_n = cursor_q + 3'd1;
					end
				end
				MODE_BACK: begin
					open_n = 1'b0;
					fin_n  = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q       <= 1'b0;
			cursor_q     <= FIELD_DATE;
			day_q        <= 5'd1;
			month_q      <= 4'd1;
			year_q       <= 7'd0;
			hour_q       <= 5'd0;
			minute_q     <= 6'd0;
			result_valid <= 1'b0;
			result_data  <= '0;
		end else begin
			if (accept) begin
				open_q                  <= open_n;
				cursor_q                <= cursor_n;
				day_q                   <= day_n;
				month_q                 <= month_n;
				year_q                  <= year_n;
				hour_q                  <= hour_n;
				minute_q                <= minute_n;
				result_valid            <= 1'b1;
				result_data.cur_date    <= day_n;
				result_data.cur_month   <= month_n;
				result_data.cur_year    <= year_n;
				result_data.cur_hours   <= hour_n;
				result_data.cur_minutes <= minute_n;
				result_data.field_index <= cursor_n;
				result_data.write_clock <= write_n;
				result_data.finished    <= fin_n;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== dv/tb_datetime_field_editor_unit.sv =====
// Testbench for the date and time field editor top level.
// Sends button event transactions, predicts each result and checks it field by field.
// Depends on dtfe_pkg and datetime_field_editor_unit.
module tb_datetime_field_editor_unit;
	import dtfe_pkg::*;

	// mode codes that the block must ignore
	localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] MODE_RESERVED_LAST  = 3'd7;
	localparam int         EVENT_TARGET        = 950;
	localparam int         LONG_HOLD_CYCLES    = 50;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    event_valid  = 1'b0;
	logic    event_stall;
	event_t  event_data   = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;

	// editor state as predicted
	logic       edit_open;
	logic [2:0] edit_cursor;
	logic [6:0] edit_day;
	logic [6:0] edit_month;
	logic [6:0] edit_year;
	logic [6:0] edit_hours;
	logic [6:0] edit_minutes;

	result_t expected_results[$];
	int      mismatch_count = 0;
	int      events_sent    = 0;
	bit      tx_calm        = 1'b0;
	bit      rx_calm        = 1'b0;
	bit      rx_hold_req    = 1'b0;

	datetime_field_editor_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_data   (event_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// step one field up or down with wraparound at its limits
	function automatic logic [6:0] wrap_field(input logic [6:0] value, input logic [6:0] lo,
			input logic [6:0] hi, input bit up);
		if (up)
			return (value < hi) ? value + 7'd1 : lo;
		return (value > lo) ? value - 7'd1 : hi;
	endfunction

	// apply one event to the predicted editor state and return the result it yields
	function automatic result_t predict_edit(input event_t ev);
		result_t r;
		bit      up;
		r = '0;
		up = (ev.mode == MODE_UP);
		if (ev.mode == MODE_START) begin
			edit_day     = {2'b00, ev.load_date};
			edit_month   = {3'b000, ev.load_month};
			edit_year    = ev.load_year;
			edit_hours   = {2'b00, ev.load_hours};
			edit_minutes = {1'b0, ev.load_minutes};
			edit_cursor  = FIELD_DATE;
			edit_open    = 1'b1;
		end else if (edit_open) begin
			case (ev.mode)
				MODE_UP, MODE_DOWN: begin
					case (edit_cursor)
						FIELD_DATE:    edit_day = wrap_field(edit_day, DATE_MIN, DATE_MAX, up);
						FIELD_MONTH:   edit_month = wrap_field(edit_month, MONTH_MIN, MONTH_MAX, up);
						FIELD_YEAR:    edit_year = wrap_field(edit_year, YEAR_MIN, YEAR_MAX, up);
						FIELD_HOURS:   edit_hours = wrap_field(edit_hours, HOURS_MIN, HOURS_MAX, up);
						FIELD_MINUTES: begin
							edit_minutes = wrap_field(edit_minutes, MINUTES_MIN, MINUTES_MAX, up);
						end
						default: ;
					endcase
				end
				MODE_OK: begin
					r.write_clock = 1'b1;
					if (edit_cursor >= FIELD_MINUTES) begin
						edit_cursor = FIELD_END;
						edit_open   = 1'b0;
						r.finished  = 1'b1;
					end else begin
						edit_cursor = edit_cursor + 3'd1;
					end
				end
				MODE_BACK: begin
					edit_open  = 1'b0;
					r.finished = 1'b1;
				end
				default: ;
			endcase
		end
		r.cur_date    = edit_day[4:0];
		r.cur_month   = edit_month[3:0];
		r.cur_year    = edit_year[6:0];
		r.cur_hours   = edit_hours[4:0];
		r.cur_minutes = edit_minutes[5:0];
		r.field_index = edit_cursor;
		return r;
	endfunction

	// event with the given code and random loads, in range or over the full width
	function automatic event_t make_event(input logic [2:0] code, input bit in_range);
		event_t ev;
		ev.mode = code;
		if (in_range) begin
			ev.load_date    = 5'($urandom_range(DATE_MIN, DATE_MAX));
			ev.load_month   = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
			ev.load_year    = 7'($urandom_range(YEAR_MIN, YEAR_MAX));
			ev.load_hours   = 5'($urandom_range(HOURS_MIN, HOURS_MAX));
			ev.load_minutes = 6'($urandom_range(MINUTES_MIN, MINUTES_MAX));
		end else begin
			ev.load_date    = 5'($urandom);
			ev.load_month   = 4'($urandom);
			ev.load_year    = 7'($urandom);
			ev.load_hours   = 5'($urandom);
			ev.load_minutes = 6'($urandom);
		end
		return ev;
	endfunction

	function automatic event_t start_with(input logic [4:0] d, input logic [3:0] m,
			input logic [6:0] y, input logic [4:0] h, input logic [5:0] mi);
		event_t ev;
		ev.mode         = MODE_START;
		ev.load_date    = d;
		ev.load_month   = m;
		ev.load_year    = y;
		ev.load_hours   = h;
		ev.load_minutes = mi;
		return ev;
	endfunction

	// offer one event transaction and record its expected result once accepted
	task automatic send_event(input event_t ev);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			event_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		event_valid <= 1'b1;
		event_data  <= ev;
		do @(posedge clk); while (event_stall);
		expected_results.push_back(predict_edit(ev));
		events_sent++;
	endtask

	task automatic check_field(input string name, input int expv, input int gotv);
		if (expv != gotv) begin
			$error("%s: expected %0d, got %0d", name, expv, gotv);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			$error("result transaction with nothing expected");
			mismatch_count++;
			return;
		end
		want = expected_results.pop_front();
		check_field("cur_date", want.cur_date, got.cur_date);
		check_field("cur_month", want.cur_month, got.cur_month);
		check_field("cur_year", want.cur_year, got.cur_year);
		check_field("cur_hours", want.cur_hours, got.cur_hours);
		check_field("cur_minutes", want.cur_minutes, got.cur_minutes);
		check_field("field_index", want.field_index, got.field_index);
		check_field("write_clock", want.write_clock, got.write_clock);
		check_field("finished", want.finished, got.finished);
	endtask

	// result side: random stalls, an occasional long hold, then take one transaction
	initial begin : result_receiver
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, 5);
			if (rx_hold_req) begin
				hold        = LONG_HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			check_result(result_data);
		end
	end

	// events outside a session, including the unused codes
	task automatic test_no_session();
		logic [2:0] code;
		send_event(make_event(MODE_UP, 1'b0));
		send_event(make_event(MODE_DOWN, 1'b0));
		send_event(make_event(MODE_OK, 1'b0));
		send_event(make_event(MODE_BACK, 1'b0));
		for (code = MODE_RESERVED_FIRST; code != MODE_START; code++)
			send_event(make_event(code, 1'b0));
	endtask

	// all-ones loads, each field stepped up or down once, closed by ok on minutes
	task automatic test_field_extremes();
		send_event(start_with('1, '1, '1, '1, '1));
		send_event(make_event(MODE_UP, 1'b0));
		send_event(make_event(MODE_OK, 1'b0));
		send_event(make_event(MODE_UP, 1'b0));
		send_event(make_event(MODE_OK, 1'b0));
		send_event(make_event(MODE_DOWN, 1'b0));
		send_event(make_event(MODE_OK, 1'b0));
		send_event(make_event(MODE_UP, 1'b0));
		send_event(make_event(MODE_OK, 1'b0));
		send_event(make_event(MODE_DOWN, 1'b0));
		send_event(make_event(MODE_OK, 1'b0));
	endtask

	// zero loads, unused code in session, restart mid-session, then back
	task automatic test_restart_and_back();
		send_event(start_with('0, '0, '0, '0, '0));
		send_event(make_event(MODE_DOWN, 1'b0));
		send_event(make_event(MODE_RESERVED_FIRST, 1'b0));
		send_event(start_with('0, '0, '0, '0, '0));
		send_event(make_event(MODE_OK, 1'b0));
		send_event(make_event(MODE_DOWN, 1'b0));
		send_event(make_event(MODE_BACK, 1'b0));
	endtask

	// receiver holds off while events keep coming, so the block stalls its input
	task automatic test_stall_fill();
		tx_calm     = 1'b1;
		rx_hold_req = 1'b1;
		send_event(make_event(MODE_START, 1'b1));
		repeat (19) send_event(make_event(3'($urandom_range(MODE_UP, MODE_OK)), 1'b0));
		tx_calm = 1'b0;
	endtask

	// well-formed sessions with random edits, with some noise between them
	task automatic test_random_sessions();
		int steps;
		int pick;
		while (events_sent < EVENT_TARGET) begin
			tx_calm = ($urandom_range(0, 7) == 0);
			rx_calm = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 7) == 0)
				send_event(make_event(3'($urandom_range(0, 7)), 1'b0));
			send_event(make_event(MODE_START, $urandom_range(0, 3) != 0));
			steps = $urandom_range(1, 30);
			repeat (steps) begin
				pick = $urandom_range(0, 99);
				if (pick < 38)
					send_event(make_event(MODE_UP, 1'b0));
				else if (pick < 76)
					send_event(make_event(MODE_DOWN, 1'b0));
				else if (pick < 92)
					send_event(make_event(MODE_OK, 1'b0));
				else if (pick < 95)
					send_event(make_event(MODE_BACK, 1'b0));
				else
					send_event(make_event(3'($urandom_range(0, 7)), 1'b0));
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// main sequence
	initial begin : main_sequence
		int drain;
		edit_open    = 1'b0;
		edit_cursor  = FIELD_DATE;
		edit_day     = DATE_MIN;
		edit_month   = MONTH_MIN;
		edit_year    = YEAR_MIN;
		edit_hours   = HOURS_MIN;
		edit_minutes = MINUTES_MIN;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_session();
		test_field_extremes();
		test_restart_and_back();
		test_stall_fill();
		test_random_sessions();
		event_valid <= 1'b0;

		// drain outstanding results
		drain = 0;
		while (expected_results.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
